// ----- src/b64c_pkg.sv -----
package b64c_pkg;

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam int unsigned NUM_SLOTS = 4;
	localparam logic REG_DECODE_MODE = 1'b0;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
		logic       out_error;
	} out_item_t;

	typedef struct packed {
		logic       bad;
		logic [5:0] value;
	} dec_char_t;

	// map a 6-bit group value to its alphabet character
	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			return 8'h41 + w;
		end else if (v < 6'd52) begin
			return 8'h61 + w - 8'd26;
		end else if (v < 6'd62) begin
			return 8'h30 + w - 8'd52;
		end else if (v == 6'd62) begin
			return 8'h2B;
		end
		return 8'h2F;
	endfunction

	// map a character to its 6-bit value; pad reads as zero, others flag bad
	function automatic dec_char_t dec_char(input logic [7:0] c);
		dec_char_t r;
		logic [7:0] d;
		r = '0;
		d = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'h41;
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'h61 + 8'd26;
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d = c - 8'h30 + 8'd52;
		end else if (c == 8'h2B) begin
			d = 8'd62;
		end else if (c == 8'h2F) begin
			d = 8'd63;
		end else if (c != PAD_CHAR) begin
			r.bad = 1'b1;
		end
		r.value = d[5:0];
		return r;
	endfunction

endpackage

// ----- src/base64_stream_codec.sv -----
// Latency: results of a group appear the cycle after the transfer that completes it,
// then leave one per cycle while out_ready is high, from a four-slot result register.
// Throughput: one input per cycle, but a group-completing transfer waits while more
// than one result of the previous group is queued, or one is and out_ready is low;
// encoding is output-port bound, decoding takes one per cycle while out_ready is high.
// Reset: arst_n clears the mode register, group state and result count and flags.
module base64_stream_codec (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  b64c_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output b64c_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import b64c_pkg::*;

	// configuration and group state
	logic        decode_mode_q;
	logic [23:0] group_bits_q;
	logic [1:0]  group_pos_q;
	logic        bad_seen_q;
	logic        pad_third_q;

	// result register: slot 0 is the one on the output port
	logic [7:0]  res_byte_q [NUM_SLOTS];
	logic [2:0]  res_count_q;
	logic        res_last_q;
	logic        res_err_q;

	// next-state values of one accepted item
	logic [23:0] bits_nxt;
	logic [1:0]  pos_nxt;
	logic        bad_nxt;
	logic        pad_third_nxt;
	logic        emit;
	logic [7:0]  emit_byte [NUM_SLOTS];
	logic [2:0]  emit_count;
	logic        emit_err;

	logic [1:0]  enc_pos;
	logic [23:0] enc_bits;
	logic [23:0] dec_bits;
	dec_char_t   dc;
	logic        is_pad;
	logic        will_emit;
	logic        slot_free;
	logic        in_xfer;
	logic        out_xfer;
	logic        cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_DECODE_MODE);
	assign prdata    = (paddr[2] == REG_DECODE_MODE) ? {31'b0, decode_mode_q} : 32'b0;

	// a group finishes on its last place or at the end of a message
	assign will_emit = decode_mode_q ? (group_pos_q == 2'd3 || in_data.in_last)
	                                 : (group_pos_q >= 2'd2 || in_data.in_last);
	// the result register is free once its last result is leaving
	assign slot_free = (res_count_q == 3'd0) || (res_count_q == 3'd1 && out_ready);
	assign in_ready  = !will_emit || slot_free;
	assign in_xfer   = in_valid && in_ready;

	assign out_valid          = (res_count_q != 3'd0);
	assign out_xfer           = out_valid && out_ready;
	assign out_data.out_byte  = res_byte_q[0];
	assign out_data.out_last  = res_last_q && (res_count_q == 3'd1);
	assign out_data.out_error = res_err_q;

	// encode: drop the byte into its place of the 24-bit group
	always_comb begin
		enc_pos = (group_pos_q == 2'd3) ? 2'd2 : group_pos_q;
		case (enc_pos)
			2'd0:    enc_bits = group_bits_q | {in_data.in_byte, 16'b0};
			2'd1:    enc_bits = group_bits_q | {8'b0, in_data.in_byte, 8'b0};
			default: enc_bits = group_bits_q | {16'b0, in_data.in_byte};
		endcase
	end

	// decode: drop the 6-bit value into its place
	always_comb begin
		dc     = dec_char(in_data.in_byte);
		is_pad = (in_data.in_byte == PAD_CHAR);
		case (group_pos_q)
			2'd0:    dec_bits = group_bits_q | {dc.value, 18'b0};
			2'd1:    dec_bits = group_bits_q | {6'b0, dc.value, 12'b0};
			2'd2:    dec_bits = group_bits_q | {12'b0, dc.value, 6'b0};
			default: dec_bits = group_bits_q | {18'b0, dc.value};
		endcase
	end

	always_comb begin
		bits_nxt      = group_bits_q;
		pos_nxt       = group_pos_q;
		bad_nxt       = bad_seen_q;
		pad_third_nxt = pad_third_q;
		emit          = 1'b0;
		emit_count    = 3'd0;
		emit_err      = 1'b0;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			emit_byte[k] = 8'h00;
		end
		if (!decode_mode_q) begin
			if (enc_pos < 2'd2 && !in_data.in_last) begin
				bits_nxt = enc_bits;
				pos_nxt  = enc_pos + 2'd1;
			end else begin
				// a short final group pads the unused places
				emit          = 1'b1;
				emit_count    = 3'd4;
				emit_byte[0]  = enc_char(enc_bits[23:18]);
				emit_byte[1]  = enc_char(enc_bits[17:12]);
				emit_byte[2]  = (enc_pos >= 2'd1) ? enc_char(enc_bits[11:6]) : PAD_CHAR;
				emit_byte[3]  = (enc_pos == 2'd2) ? enc_char(enc_bits[5:0]) : PAD_CHAR;
				bits_nxt      = '0;
				pos_nxt       = 2'd0;
				pad_third_nxt = 1'b0;
			end
		end else begin
			bad_nxt = bad_seen_q | dc.bad;
			if (group_pos_q == 2'd2) begin
				pad_third_nxt = is_pad;
			end
			if (group_pos_q != 2'd3) begin
				if (in_data.in_last) begin
					// message ended inside a group: one error result, drop the group
					emit          = 1'b1;
					emit_count    = 3'd1;
					emit_err      = 1'b1;
					bits_nxt      = '0;
					pos_nxt       = 2'd0;
					pad_third_nxt = 1'b0;
					bad_nxt       = 1'b0;
				end else begin
					bits_nxt = dec_bits;
					pos_nxt  = group_pos_q + 2'd1;
				end
			end else begin
				emit         = 1'b1;
				emit_err     = bad_nxt;
				emit_byte[0] = dec_bits[23:16];
				emit_byte[1] = dec_bits[15:8];
				emit_byte[2] = dec_bits[7:0];
				// each pad in the third or fourth place of the final group drops a byte
				emit_count   = 3'd3 - {2'b00, in_data.in_last && is_pad}
				                    - {2'b00, in_data.in_last && pad_third_q};
				bits_nxt      = '0;
				pos_nxt       = 2'd0;
				pad_third_nxt = 1'b0;
				if (in_data.in_last) begin
					bad_nxt = 1'b0;
				end
			end
		end
	end

	// group state and mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q <= 1'b0;
			group_bits_q  <= '0;
			group_pos_q   <= 2'd0;
			bad_seen_q    <= 1'b0;
			pad_third_q   <= 1'b0;
		end else if (cfg_write) begin
			// a mode write starts a fresh message
			decode_mode_q <= pwdata[0];
			group_bits_q  <= '0;
			group_pos_q   <= 2'd0;
			bad_seen_q    <= 1'b0;
			pad_third_q   <= 1'b0;
		end else if (in_xfer) begin
			group_bits_q <= bits_nxt;
			group_pos_q  <= pos_nxt;
			bad_seen_q   <= bad_nxt;
			pad_third_q  <= pad_third_nxt;
		end
	end

	// result count and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_count_q <= 3'd0;
			res_last_q  <= 1'b0;
			res_err_q   <= 1'b0;
		end else if (in_xfer && emit) begin
			res_count_q <= emit_count;
			res_last_q  <= in_data.in_last;
			res_err_q   <= emit_err;
		end else if (out_xfer) begin
			res_count_q <= res_count_q - 3'd1;
		end
	end

	// result bytes: load a new group, else advance one slot per output transfer
	always_ff @(posedge clk) begin
		if (in_xfer && emit) begin
			for (int k = 0; k < NUM_SLOTS; k++) begin
				res_byte_q[k] <= emit_byte[k];
			end
		end else if (out_xfer) begin
			for (int k = 0; k < NUM_SLOTS - 1; k++) begin
				res_byte_q[k] <= res_byte_q[k + 1];
			end
		end
	end

endmodule
